// ----- hw/rtl/osfb_pkg.sv -----
package osfb_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_A_TOP   = 3'd0,
        CFG_A_BOT   = 3'd1,
        CFG_B_COL   = 3'd2,
        CFG_C_ROW   = 3'd3,
        CFG_L_GAIN  = 3'd4,
        CFG_K_GAIN  = 3'd5,
        CFG_D       = 3'd6,
        CFG_DT      = 3'd7
    } t_cfg_idx;

    // Multiplier operand selects.
    typedef enum logic [4:0] {
        OPN_K0, OPN_K1, OPN_C0, OPN_C1, OPN_D,
        OPN_A00, OPN_A01, OPN_A10, OPN_A11,
        OPN_B0, OPN_B1, OPN_L0, OPN_L1,
        OPN_DT, OPN_ONE, OPN_ACC,
        OPN_H0, OPN_H1, OPN_X0, OPN_X1,
        OPN_U, OPN_E, OPN_HD0, OPN_HD1, OPN_XD0, OPN_XD1
    } t_opnd;

    // Value that the product is added to or taken from.
    typedef enum logic [2:0] {
        BS_ACC, BS_ZERO, BS_REF, BS_Y, BS_H0, BS_H1, BS_X0, BS_X1
    } t_base;

    // Where the accumulated word is kept besides the accumulator.
    typedef enum logic [3:0] {
        DS_ACC, DS_U, DS_Y, DS_E, DS_HD0, DS_HD1, DS_XD0, DS_XD1,
        DS_H0, DS_H1, DS_X0, DS_X1
    } t_dest;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        t_base base;
        logic  neg;
        t_dest dest;
    } t_uop;

    localparam int UOP_COUNT = 26;
    localparam logic [4:0] LAST_UOP = 5'(UOP_COUNT - 1);

    // One multiply and one saturating add or subtract per step.
    function automatic t_uop uop_at(input logic [4:0] idx);
        t_uop u;
        unique case (idx)
            5'd0:  u = '{OPN_K0,  OPN_H0,  BS_REF,  1'b1, DS_ACC};
            5'd1:  u = '{OPN_K1,  OPN_H1,  BS_ACC,  1'b1, DS_U};
            5'd2:  u = '{OPN_C0,  OPN_X0,  BS_ZERO, 1'b0, DS_ACC};
            5'd3:  u = '{OPN_C1,  OPN_X1,  BS_ACC,  1'b0, DS_ACC};
            5'd4:  u = '{OPN_D,   OPN_U,   BS_ACC,  1'b0, DS_Y};
            5'd5:  u = '{OPN_C0,  OPN_H0,  BS_ZERO, 1'b0, DS_ACC};
            5'd6:  u = '{OPN_C1,  OPN_H1,  BS_ACC,  1'b0, DS_ACC};
            // Multiplying by one passes the estimated output through unchanged.
            5'd7:  u = '{OPN_ACC, OPN_ONE, BS_Y,    1'b1, DS_E};
            5'd8:  u = '{OPN_A00, OPN_H0,  BS_ZERO, 1'b0, DS_ACC};
            5'd9:  u = '{OPN_A01, OPN_H1,  BS_ACC,  1'b0, DS_ACC};
            5'd10: u = '{OPN_B0,  OPN_U,   BS_ACC,  1'b0, DS_ACC};
            5'd11: u = '{OPN_L0,  OPN_E,   BS_ACC,  1'b0, DS_HD0};
            5'd12: u = '{OPN_A10, OPN_H0,  BS_ZERO, 1'b0, DS_ACC};
            5'd13: u = '{OPN_A11, OPN_H1,  BS_ACC,  1'b0, DS_ACC};
            5'd14: u = '{OPN_B1,  OPN_U,   BS_ACC,  1'b0, DS_ACC};
            5'd15: u = '{OPN_L1,  OPN_E,   BS_ACC,  1'b0, DS_HD1};
            5'd16: u = '{OPN_A00, OPN_X0,  BS_ZERO, 1'b0, DS_ACC};
            5'd17: u = '{OPN_A01, OPN_X1,  BS_ACC,  1'b0, DS_ACC};
            5'd18: u = '{OPN_B0,  OPN_U,   BS_ACC,  1'b0, DS_XD0};
            5'd19: u = '{OPN_A10, OPN_X0,  BS_ZERO, 1'b0, DS_ACC};
            5'd20: u = '{OPN_A11, OPN_X1,  BS_ACC,  1'b0, DS_ACC};
            5'd21: u = '{OPN_B1,  OPN_U,   BS_ACC,  1'b0, DS_XD1};
            // State updates come last, so every derivative saw the old state.
            5'd22: u = '{OPN_HD0, OPN_DT,  BS_H0,   1'b0, DS_H0};
            5'd23: u = '{OPN_HD1, OPN_DT,  BS_H1,   1'b0, DS_H1};
            5'd24: u = '{OPN_XD0, OPN_DT,  BS_X0,   1'b0, DS_X0};
            5'd25: u = '{OPN_XD1, OPN_DT,  BS_X1,   1'b0, DS_X1};
            default: u = '{OPN_ONE, OPN_ONE, BS_ACC, 1'b0, DS_ACC};
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/observer_state_feedback_step.sv -----
// Channel   | Direction | Handshake                | Word
// ----------+-----------+--------------------------+----------------------------------------
// input     | in        | i_valid / o_stall        | i_reference, i_restart
// result    | out       | o_valid / i_stall        | o_plant_output, o_control_value,
//           |           |                          | o_estimate_first, o_estimate_second
// config    | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One word takes 26 multiply-accumulate steps, each a multiply state then an accumulate
// state, on the single shared multiplier; no new word is taken until it is through.
// Its result is loaded from the done state, and the next word can be taken in the cycle
// after the load. A finished result waits in the output register; the sequencer waits in
// its done state while an older result is still stalled there.
// Reset is synchronous: registers go to their defaults, plant state to zero and the
// estimate to 0.001. Configuration is always ready.
module observer_state_feedback_step #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_reference,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_plant_output,
    output logic [31:0] o_control_value,
    output logic [31:0] o_estimate_first,
    output logic [31:0] o_estimate_second,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [VALUE_WIDTH-1:0] EST_INIT =
        VALUE_WIDTH'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [30:0] DT_RESET = 31'd6554;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_w(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > VMAX) begin
            c = VMAX;
        end else if (v < VMIN) begin
            c = VMIN;
        end else begin
            c = v;
        end
        return c[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] entry(input logic [31:0] raw);
        return sat_w(64'($signed(raw)));
    endfunction

    osfb_pkg::t_state r_state, n_state;
    logic [4:0]       r_idx, n_idx;
    logic             accept, mul_phase, acc_phase, load_out;
    osfb_pkg::t_uop   uop;

    // Configuration registers.
    logic [63:0]        r_a_top, r_a_bot, r_b_col, r_c_row, r_l_gain, r_k_gain;
    logic [31:0]        r_d;
    logic [30:0]        r_dt;

    // Loop state and per-word temporaries.
    logic signed [VALUE_WIDTH-1:0] r_h0, r_h1, r_x0, r_x1;
    logic signed [VALUE_WIDTH-1:0] r_ref, r_prod, r_acc, r_u, r_y, r_e;
    logic signed [VALUE_WIDTH-1:0] r_hd0, r_hd1, r_xd0, r_xd1;
    logic signed [VALUE_WIDTH-1:0] r_out_y, r_out_u, r_out_h0, r_out_h1;
    logic                          r_out_valid;

    logic signed [31:0]            opa, opb;
    logic signed [63:0]            prod_full;
    logic signed [VALUE_WIDTH-1:0] base, acc_res;
    logic signed [63:0]            sum;

    function automatic logic signed [31:0] pick(input osfb_pkg::t_opnd s);
        logic signed [31:0] v;
        case (s)
            osfb_pkg::OPN_K0:  v = 32'(entry(r_k_gain[31:0]));
            osfb_pkg::OPN_K1:  v = 32'(entry(r_k_gain[63:32]));
            osfb_pkg::OPN_C0:  v = 32'(entry(r_c_row[31:0]));
            osfb_pkg::OPN_C1:  v = 32'(entry(r_c_row[63:32]));
            osfb_pkg::OPN_D:   v = 32'(entry(r_d));
            osfb_pkg::OPN_A00: v = 32'(entry(r_a_top[31:0]));
            osfb_pkg::OPN_A01: v = 32'(entry(r_a_top[63:32]));
            osfb_pkg::OPN_A10: v = 32'(entry(r_a_bot[31:0]));
            osfb_pkg::OPN_A11: v = 32'(entry(r_a_bot[63:32]));
            osfb_pkg::OPN_B0:  v = 32'(entry(r_b_col[31:0]));
            osfb_pkg::OPN_B1:  v = 32'(entry(r_b_col[63:32]));
            osfb_pkg::OPN_L0:  v = 32'(entry(r_l_gain[31:0]));
            osfb_pkg::OPN_L1:  v = 32'(entry(r_l_gain[63:32]));
            osfb_pkg::OPN_DT:  v = $signed({1'b0, r_dt});
            osfb_pkg::OPN_ONE: v = ONE_Q;
            osfb_pkg::OPN_ACC: v = 32'(r_acc);
            osfb_pkg::OPN_H0:  v = 32'(r_h0);
            osfb_pkg::OPN_H1:  v = 32'(r_h1);
            osfb_pkg::OPN_X0:  v = 32'(r_x0);
            osfb_pkg::OPN_X1:  v = 32'(r_x1);
            osfb_pkg::OPN_U:   v = 32'(r_u);
            osfb_pkg::OPN_E:   v = 32'(r_e);
            osfb_pkg::OPN_HD0: v = 32'(r_hd0);
            osfb_pkg::OPN_HD1: v = 32'(r_hd1);
            osfb_pkg::OPN_XD0: v = 32'(r_xd0);
            osfb_pkg::OPN_XD1: v = 32'(r_xd1);
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign uop = osfb_pkg::uop_at(r_idx);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osfb_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        accept    = 1'b0;
        mul_phase = 1'b0;
        acc_phase = 1'b0;
        load_out  = 1'b0;
        o_stall   = 1'b1;
        unique case (r_state)
            osfb_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    accept  = 1'b1;
                    n_idx   = '0;
                    n_state = osfb_pkg::ST_MUL;
                end
            end
            osfb_pkg::ST_MUL: begin
                mul_phase = 1'b1;
                n_state   = osfb_pkg::ST_ACC;
            end
            osfb_pkg::ST_ACC: begin
                acc_phase = 1'b1;
                if (r_idx == osfb_pkg::LAST_UOP) begin
                    n_state = osfb_pkg::ST_DONE;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = osfb_pkg::ST_MUL;
                end
            end
            osfb_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = osfb_pkg::ST_IDLE;
                end
            end
            default: n_state = osfb_pkg::ST_IDLE;
        endcase
    end

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_top  <= '0;
            r_a_bot  <= '0;
            r_b_col  <= '0;
            r_c_row  <= '0;
            r_l_gain <= '0;
            r_k_gain <= '0;
            r_d      <= '0;
            r_dt     <= DT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (osfb_pkg::t_cfg_idx'(i_cfg_index))
                osfb_pkg::CFG_A_TOP:  r_a_top  <= i_cfg_data;
                osfb_pkg::CFG_A_BOT:  r_a_bot  <= i_cfg_data;
                osfb_pkg::CFG_B_COL:  r_b_col  <= i_cfg_data;
                osfb_pkg::CFG_C_ROW:  r_c_row  <= i_cfg_data;
                osfb_pkg::CFG_L_GAIN: r_l_gain <= i_cfg_data;
                osfb_pkg::CFG_K_GAIN: r_k_gain <= i_cfg_data;
                osfb_pkg::CFG_D:      r_d      <= i_cfg_data[31:0];
                osfb_pkg::CFG_DT:     r_dt     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier and saturating accumulator.
    always_comb begin
        opa       = pick(uop.a);
        opb       = pick(uop.b);
        prod_full = 64'(opa) * 64'(opb);
        case (uop.base)
            osfb_pkg::BS_ACC:  base = r_acc;
            osfb_pkg::BS_ZERO: base = '0;
            osfb_pkg::BS_REF:  base = r_ref;
            osfb_pkg::BS_Y:    base = r_y;
            osfb_pkg::BS_H0:   base = r_h0;
            osfb_pkg::BS_H1:   base = r_h1;
            osfb_pkg::BS_X0:   base = r_x0;
            osfb_pkg::BS_X1:   base = r_x1;
            default:           base = '0;
        endcase
        sum     = uop.neg ? (64'(base) - 64'(r_prod)) : (64'(base) + 64'(r_prod));
        acc_res = sat_w(sum);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ref <= entry(i_reference);
        end
        if (mul_phase) begin
            // The arithmetic shift rounds the product toward minus infinity.
            r_prod <= sat_w(prod_full >>> FRAC_BITS);
        end
        if (acc_phase) begin
            r_acc <= acc_res;
            case (uop.dest)
                osfb_pkg::DS_U:   r_u   <= acc_res;
                osfb_pkg::DS_Y:   r_y   <= acc_res;
                osfb_pkg::DS_E:   r_e   <= acc_res;
                osfb_pkg::DS_HD0: r_hd0 <= acc_res;
                osfb_pkg::DS_HD1: r_hd1 <= acc_res;
                osfb_pkg::DS_XD0: r_xd0 <= acc_res;
                osfb_pkg::DS_XD1: r_xd1 <= acc_res;
                default: ;
            endcase
        end
    end

    // Plant and estimate state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_restart)) begin
            r_x0 <= '0;
            r_x1 <= '0;
            r_h0 <= EST_INIT;
            r_h1 <= EST_INIT;
        end else if (acc_phase) begin
            case (uop.dest)
                osfb_pkg::DS_H0: r_h0 <= acc_res;
                osfb_pkg::DS_H1: r_h1 <= acc_res;
                osfb_pkg::DS_X0: r_x0 <= acc_res;
                osfb_pkg::DS_X1: r_x1 <= acc_res;
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_y  <= r_y;
            r_out_u  <= r_u;
            r_out_h0 <= r_h0;
            r_out_h1 <= r_h1;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_plant_output    = 32'(r_out_y);
    assign o_control_value   = 32'(r_out_u);
    assign o_estimate_first  = 32'(r_out_h0);
    assign o_estimate_second = 32'(r_out_h1);

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == osfb_pkg::ST_MUL && r_idx == 5'd0))
        else $error("accepted word did not start the step sequence");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= osfb_pkg::LAST_UOP)
        else $error("step counter ran past the last step");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osfb_pkg::ST_DONE && !(r_out_valid && i_stall)) |=>
        (o_valid && r_state == osfb_pkg::ST_IDLE))
        else $error("finished word was not loaded into the output register");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_restart) |=>
        (r_x0 == '0 && r_x1 == '0 && r_h0 == EST_INIT && r_h1 == EST_INIT))
        else $error("restart did not reload the initial state");
`endif

endmodule
